### rtl/core/i2cmwe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmwe_pkg
// Shared types and constants for the I2C master write engine.
// ----------------------------------------------------------------------------
package i2cmwe_pkg;

    localparam int DELAY_WIDTH = 16;
    localparam int TICKS_W     = 16;
    localparam int CMP_W       = ((DELAY_WIDTH > TICKS_W) ? DELAY_WIDTH : TICKS_W) + 2;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET = 16'd80;
    localparam logic [CMP_W-1:0]   PHASE_CAP         = CMP_W'(1) << DELAY_WIDTH;
    localparam logic [2:0]         BIT_TOP           = 3'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_CODE_TICK   = 2'd0;
    localparam logic [1:0] REQ_CODE_BEGIN  = 2'd1;
    localparam logic [1:0] REQ_CODE_SUPPLY = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_BEGIN,
        REQ_SUPPLY,
        REQ_NONE
    } req_kind_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_START_C,
        PH_BIT_SET,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_ACK_SET,
        PH_ACK_HIGH,
        PH_ACK_LOW,
        PH_WAIT_BYTE,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [6:0]  addr7;
        logic [15:0] byte_count;
        logic [7:0]  data_byte;
        logic        sda_in;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

### rtl/core/i2cmwe_front.sv
// ----------------------------------------------------------------------------
// i2cmwe_front
// Accepts input words, decodes the request type and queues them for the
// line engine.
// ----------------------------------------------------------------------------
module i2cmwe_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [6:0]            addr7,
    input  logic [15:0]           byte_count,
    input  logic [7:0]            data_byte,
    input  logic                  sda_in,
    output i2cmwe_pkg::queue_head_t head,
    input  logic                  pop
);

    i2cmwe_pkg::item_t                   queue_mem [i2cmwe_pkg::QUEUE_DEPTH];
    logic [i2cmwe_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [i2cmwe_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [i2cmwe_pkg::QCNT_W-1:0]       count_reg, count_next;
    i2cmwe_pkg::item_t                   item_in;
    logic                                push;
    logic                                do_pop;

    always_comb
    begin
        item_in.addr7      = addr7;
        item_in.byte_count = byte_count;
        item_in.data_byte  = data_byte;
        item_in.sda_in     = sda_in;
        unique case (req_type)
            i2cmwe_pkg::REQ_CODE_TICK:   item_in.kind = i2cmwe_pkg::REQ_TICK;
            i2cmwe_pkg::REQ_CODE_BEGIN:  item_in.kind = i2cmwe_pkg::REQ_BEGIN;
            i2cmwe_pkg::REQ_CODE_SUPPLY: item_in.kind = i2cmwe_pkg::REQ_SUPPLY;
            default:                     item_in.kind = i2cmwe_pkg::REQ_NONE;
        endcase
    end

    assign in_stall = (count_reg == i2cmwe_pkg::QCNT_W'(i2cmwe_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? i2cmwe_pkg::QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? i2cmwe_pkg::QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = i2cmwe_pkg::QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !push)
        begin
            count_next = i2cmwe_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/i2cmwe_back.sv
// ----------------------------------------------------------------------------
// i2cmwe_back
// Line phase machine: advances the START/address/data/ACK/STOP sequence and
// registers the result word; one queued word per cycle when not stalled.
// ----------------------------------------------------------------------------
module i2cmwe_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [15:0]             cfg_wdata,
    input  i2cmwe_pkg::queue_head_t head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    scl_pull_low,
    output logic                    sda_pull_low,
    output logic                    busy_res,
    output logic                    byte_wanted,
    output logic                    done_res,
    output logic                    nack
);

    i2cmwe_pkg::phase_t                      phase_reg, phase_next;
    logic [i2cmwe_pkg::DELAY_WIDTH-1:0]      delay_reg, delay_next;
    logic [7:0]                              shift_reg, shift_next;
    logic [2:0]                              bit_index_reg, bit_index_next;
    logic [15:0]                             bytes_left_reg, bytes_left_next;
    logic [7:0]                              buffer_reg, buffer_next;
    logic                                    full_reg, full_next;
    logic                                    nack_flag_reg, nack_flag_next;
    logic [i2cmwe_pkg::TICKS_W-1:0]          phase_ticks_reg;

    logic                                    res_valid_reg, res_valid_next;
    logic                                    scl_reg, scl_next;
    logic                                    sda_reg, sda_next;
    logic                                    busy_reg, busy_next;
    logic                                    wanted_reg, wanted_next;
    logic                                    done_reg, done_next;
    logic                                    nack_reg, nack_next;

    logic [i2cmwe_pkg::CMP_W-1:0]            phase_len;
    logic [i2cmwe_pkg::CMP_W-1:0]            count_plus1;
    logic                                    phase_end;
    logic                                    load_req;
    logic                                    busy_now;
    logic                                    bitv;
    i2cmwe_pkg::item_t                       it;

    assign it  = head.item;
    assign pop = head.valid && (!res_valid_reg || !out_stall);

    always_comb
    begin
        phase_len = i2cmwe_pkg::CMP_W'(phase_ticks_reg);
        if (phase_ticks_reg == '0)
        begin
            phase_len = i2cmwe_pkg::CMP_W'(1);
        end
        if (phase_len > i2cmwe_pkg::PHASE_CAP)
        begin
            phase_len = i2cmwe_pkg::PHASE_CAP;
        end
        count_plus1 = i2cmwe_pkg::CMP_W'(delay_reg) + i2cmwe_pkg::CMP_W'(1);
        phase_end   = (count_plus1 >= phase_len);
    end

    assign busy_now = (phase_reg != i2cmwe_pkg::PH_IDLE);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        delay_next      = delay_reg;
        shift_next      = shift_reg;
        bit_index_next  = bit_index_reg;
        bytes_left_next = bytes_left_reg;
        buffer_next     = buffer_reg;
        full_next       = full_reg;
        nack_flag_next  = nack_flag_reg;
        done_next       = 1'b0;
        load_req        = 1'b0;

        unique case (it.kind)
            i2cmwe_pkg::REQ_TICK:
            begin
                if (phase_reg == i2cmwe_pkg::PH_IDLE)
                begin
                    phase_next = i2cmwe_pkg::PH_IDLE;
                end
                else if (phase_reg == i2cmwe_pkg::PH_WAIT_BYTE)
                begin
                    load_req = 1'b1;
                end
                else if (!phase_end)
                begin
                    delay_next = i2cmwe_pkg::DELAY_WIDTH'(delay_reg + 1'b1);
                end
                else
                begin
                    delay_next = '0;
                    unique case (phase_reg)
                        i2cmwe_pkg::PH_START_A:  phase_next = i2cmwe_pkg::PH_START_B;
                        i2cmwe_pkg::PH_START_B:  phase_next = i2cmwe_pkg::PH_START_C;
                        i2cmwe_pkg::PH_START_C:
                        begin
                            bit_index_next = i2cmwe_pkg::BIT_TOP;
                            phase_next     = i2cmwe_pkg::PH_BIT_SET;
                        end
                        i2cmwe_pkg::PH_BIT_SET:  phase_next = i2cmwe_pkg::PH_BIT_HIGH;
                        i2cmwe_pkg::PH_BIT_HIGH: phase_next = i2cmwe_pkg::PH_BIT_LOW;
                        i2cmwe_pkg::PH_BIT_LOW:
                        begin
                            if (bit_index_reg == '0)
                            begin
                                phase_next = i2cmwe_pkg::PH_ACK_SET;
                            end
                            else
                            begin
                                bit_index_next = 3'(bit_index_reg - 1'b1);
                                phase_next     = i2cmwe_pkg::PH_BIT_SET;
                            end
                        end
                        i2cmwe_pkg::PH_ACK_SET:  phase_next = i2cmwe_pkg::PH_ACK_HIGH;
                        i2cmwe_pkg::PH_ACK_HIGH:
                        begin
                            nack_flag_next = it.sda_in;
                            phase_next     = i2cmwe_pkg::PH_ACK_LOW;
                        end
                        i2cmwe_pkg::PH_ACK_LOW:
                        begin
                            if (nack_flag_reg || (bytes_left_reg == '0))
                            begin
                                full_next  = 1'b0;
                                phase_next = i2cmwe_pkg::PH_STOP_A;
                            end
                            else if (full_reg)
                            begin
                                load_req = 1'b1;
                            end
                            else
                            begin
                                phase_next = i2cmwe_pkg::PH_WAIT_BYTE;
                            end
                        end
                        i2cmwe_pkg::PH_STOP_A:   phase_next = i2cmwe_pkg::PH_STOP_B;
                        i2cmwe_pkg::PH_STOP_B:   phase_next = i2cmwe_pkg::PH_STOP_C;
                        i2cmwe_pkg::PH_STOP_C:
                        begin
                            phase_next = i2cmwe_pkg::PH_IDLE;
                            done_next  = 1'b1;
                        end
                        default:                 phase_next = i2cmwe_pkg::PH_IDLE;
                    endcase
                end
            end
            i2cmwe_pkg::REQ_BEGIN:
            begin
                if (!busy_now)
                begin
                    shift_next      = {it.addr7, 1'b0};
                    bytes_left_next = it.byte_count;
                    full_next       = 1'b0;
                    nack_flag_next  = 1'b0;
                    bit_index_next  = i2cmwe_pkg::BIT_TOP;
                    phase_next      = i2cmwe_pkg::PH_START_A;
                    delay_next      = '0;
                end
            end
            i2cmwe_pkg::REQ_SUPPLY:
            begin
                if (busy_now && !full_reg && (bytes_left_reg != '0))
                begin
                    buffer_next = it.data_byte;
                    full_next   = 1'b1;
                end
            end
            i2cmwe_pkg::REQ_NONE:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (load_req && full_reg)
        begin
            shift_next      = buffer_reg;
            full_next       = 1'b0;
            bytes_left_next = 16'(bytes_left_reg - 1'b1);
            bit_index_next  = i2cmwe_pkg::BIT_TOP;
            phase_next      = i2cmwe_pkg::PH_BIT_SET;
            delay_next      = '0;
        end
    end

    // result word, from the state after this word
    always_comb
    begin
        bitv        = shift_next[bit_index_next];
        scl_next    = 1'b0;
        sda_next    = 1'b0;
        busy_next   = (phase_next != i2cmwe_pkg::PH_IDLE);
        wanted_next = busy_next && !full_next && (bytes_left_next != '0);
        nack_next   = done_next && nack_flag_reg;
        unique case (phase_next)
            i2cmwe_pkg::PH_START_B:   sda_next = 1'b1;
            i2cmwe_pkg::PH_START_C:
            begin
                scl_next = 1'b1;
                sda_next = 1'b1;
            end
            i2cmwe_pkg::PH_BIT_SET:
            begin
                scl_next = 1'b1;
                sda_next = !bitv;
            end
            i2cmwe_pkg::PH_BIT_HIGH:  sda_next = !bitv;
            i2cmwe_pkg::PH_BIT_LOW:
            begin
                scl_next = 1'b1;
                sda_next = !bitv;
            end
            i2cmwe_pkg::PH_ACK_SET:   scl_next = 1'b1;
            i2cmwe_pkg::PH_ACK_LOW:   scl_next = 1'b1;
            i2cmwe_pkg::PH_WAIT_BYTE: scl_next = 1'b1;
            i2cmwe_pkg::PH_STOP_A:
            begin
                scl_next = 1'b1;
                sda_next = 1'b1;
            end
            i2cmwe_pkg::PH_STOP_B:    sda_next = 1'b1;
            default:                  scl_next = 1'b0;
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buffer_reg <= buffer_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            busy_reg   <= busy_next;
            wanted_reg <= wanted_next;
            done_reg   <= done_next;
            nack_reg   <= nack_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cmwe_pkg::PH_IDLE;
            delay_reg       <= '0;
            shift_reg       <= '0;
            bit_index_reg   <= '0;
            bytes_left_reg  <= '0;
            full_reg        <= 1'b0;
            nack_flag_reg   <= 1'b0;
            phase_ticks_reg <= i2cmwe_pkg::PHASE_TICKS_RESET;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                delay_reg      <= delay_next;
                shift_reg      <= shift_next;
                bit_index_reg  <= bit_index_next;
                bytes_left_reg <= bytes_left_next;
                full_reg       <= full_next;
                nack_flag_reg  <= nack_flag_next;
            end
            if (cfg_we)
            begin
                phase_ticks_reg <= cfg_wdata;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign scl_pull_low = scl_reg;
    assign sda_pull_low = sda_reg;
    assign busy_res     = busy_reg;
    assign byte_wanted  = wanted_reg;
    assign done_res     = done_reg;
    assign nack         = nack_reg;

endmodule

### rtl/core/i2c_master_write_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_write_engine
// Open-drain I2C master for write transactions: begin, data and tick words
// in, one line/status word out per input word.
// ----------------------------------------------------------------------------
// One input word is taken every clock while in_stall is low, and each gives
// exactly one result word. Words pass through a two-entry queue into the
// phase machine, which handles one word a cycle while its output register
// is free or being read, and writes its result into that register; the
// queue absorbs output stalls so the input keeps flowing until it fills.
// phase_ticks sets the tick words per SCL/SDA phase (zero counts as one).
module i2c_master_write_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [6:0]  addr7,
    input  logic [15:0] byte_count,
    input  logic [7:0]  data_byte,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_pull_low,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic        byte_wanted,
    output logic        done_res,
    output logic        nack
);

    i2cmwe_pkg::queue_head_t head;
    logic                    pop;

    i2cmwe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .addr7      (addr7),
        .byte_count (byte_count),
        .data_byte  (data_byte),
        .sda_in     (sda_in),
        .head       (head),
        .pop        (pop)
    );

    i2cmwe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_pull_low (scl_pull_low),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .byte_wanted  (byte_wanted),
        .done_res     (done_res),
        .nack         (nack)
    );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master write engine. Begin, data and tick
// words are fed through the valid/stall input, and every result word is
// checked against a fixed scripted word or the bench's own model of the line
// sequencer. The run has a short scripted section, then random write
// transfers under several phase_ticks settings and idle/stall mixes,
// including a long output hold-off. It ends by starting a transfer at the
// largest phase_ticks value and ticking the phase counter while START_A holds.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic want;
        logic done;
        logic nk;
    } line_res_t;

    typedef struct {
        logic [1:0]  rq;
        logic [6:0]  a;
        logic [15:0] n;
        logic [7:0]  d;
        logic        s;
        int          reps;
        logic        typed;
        line_res_t   res;
    } script_row_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_wdata  = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type   = '0;
    logic [6:0]  addr7      = '0;
    logic [15:0] byte_count = '0;
    logic [7:0]  data_byte  = '0;
    logic        sda_in     = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        scl_pull_low;
    logic        sda_pull_low;
    logic        busy_res;
    logic        byte_wanted;
    logic        done_res;
    logic        nack;

    // model of the line sequencer
    i2cmwe_pkg::phase_t line_ph   = i2cmwe_pkg::PH_IDLE;
    logic [15:0]        dly_cnt   = '0;
    logic [7:0]         shifter   = '0;
    logic [2:0]         bit_pos   = '0;
    logic [15:0]        bytes_rem = '0;
    logic [7:0]         pend_byte = '0;
    logic               pend_full = 1'b0;
    logic               nack_seen = 1'b0;
    logic [15:0]        tick_len  = i2cmwe_pkg::PHASE_TICKS_RESET;

    line_res_t   line_results_due[$];
    script_row_t script [0:21];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    logic hold_req    = 1'b0;
    int hold_left     = 0;

    int words_sent    = 0;
    int results_seen  = 0;
    int transfers     = 0;
    int nack_ends     = 0;
    int input_holds   = 0;
    int fail_count    = 0;
    int rand_ticks    = 0;

    i2c_master_write_engine u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .addr7        (addr7),
        .byte_count   (byte_count),
        .data_byte    (data_byte),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_pull_low (scl_pull_low),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .byte_wanted  (byte_wanted),
        .done_res     (done_res),
        .nack         (nack)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void enter_phase(i2cmwe_pkg::phase_t p);
        line_ph = p;
        dly_cnt = '0;
    endfunction

    function automatic logic load_pending();
        if (!pend_full)
            return 1'b0;
        shifter   = pend_byte;
        pend_full = 1'b0;
        bytes_rem = bytes_rem - 16'd1;
        bit_pos   = i2cmwe_pkg::BIT_TOP;
        enter_phase(i2cmwe_pkg::PH_BIT_SET);
        return 1'b1;
    endfunction

    // one tick of the sequencer; returns 1 when STOP completes
    function automatic logic advance_line(logic sda);
        logic [16:0] span;
        span = (tick_len == '0) ? 17'd1 : {1'b0, tick_len};
        if (line_ph == i2cmwe_pkg::PH_IDLE)
            return 1'b0;
        if (line_ph == i2cmwe_pkg::PH_WAIT_BYTE)
        begin
            void'(load_pending());
            return 1'b0;
        end
        if ({1'b0, dly_cnt} + 17'd1 < span)
        begin
            dly_cnt = dly_cnt + 16'd1;
            return 1'b0;
        end
        case (line_ph)
            i2cmwe_pkg::PH_START_A:  enter_phase(i2cmwe_pkg::PH_START_B);
            i2cmwe_pkg::PH_START_B:  enter_phase(i2cmwe_pkg::PH_START_C);
            i2cmwe_pkg::PH_START_C:
            begin
                bit_pos = i2cmwe_pkg::BIT_TOP;
                enter_phase(i2cmwe_pkg::PH_BIT_SET);
            end
            i2cmwe_pkg::PH_BIT_SET:  enter_phase(i2cmwe_pkg::PH_BIT_HIGH);
            i2cmwe_pkg::PH_BIT_HIGH: enter_phase(i2cmwe_pkg::PH_BIT_LOW);
            i2cmwe_pkg::PH_BIT_LOW:
            begin
                if (bit_pos == 3'd0)
                    enter_phase(i2cmwe_pkg::PH_ACK_SET);
                else
                begin
                    bit_pos = bit_pos - 3'd1;
                    enter_phase(i2cmwe_pkg::PH_BIT_SET);
                end
            end
            i2cmwe_pkg::PH_ACK_SET:  enter_phase(i2cmwe_pkg::PH_ACK_HIGH);
            i2cmwe_pkg::PH_ACK_HIGH:
            begin
                nack_seen = sda;
                enter_phase(i2cmwe_pkg::PH_ACK_LOW);
            end
            i2cmwe_pkg::PH_ACK_LOW:
            begin
                if (nack_seen || bytes_rem == '0)
                begin
                    pend_full = 1'b0;
                    enter_phase(i2cmwe_pkg::PH_STOP_A);
                end
                else if (!load_pending())
                    enter_phase(i2cmwe_pkg::PH_WAIT_BYTE);
            end
            i2cmwe_pkg::PH_STOP_A:   enter_phase(i2cmwe_pkg::PH_STOP_B);
            i2cmwe_pkg::PH_STOP_B:   enter_phase(i2cmwe_pkg::PH_STOP_C);
            default:
            begin
                enter_phase(i2cmwe_pkg::PH_IDLE);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic line_res_t line_after_word(logic [1:0] rq, logic [6:0] a,
                                                  logic [15:0] n, logic [7:0] d,
                                                  logic s);
        line_res_t r;
        logic busy, done, bv;
        busy = (line_ph != i2cmwe_pkg::PH_IDLE);
        done = 1'b0;
        if (rq == i2cmwe_pkg::REQ_CODE_TICK)
            done = advance_line(s);
        else if (rq == i2cmwe_pkg::REQ_CODE_BEGIN)
        begin
            if (!busy)
            begin
                shifter   = {a, 1'b0};
                bytes_rem = n;
                pend_full = 1'b0;
                nack_seen = 1'b0;
                bit_pos   = i2cmwe_pkg::BIT_TOP;
                enter_phase(i2cmwe_pkg::PH_START_A);
            end
        end
        else if (rq == i2cmwe_pkg::REQ_CODE_SUPPLY)
        begin
            if (busy && !pend_full && bytes_rem != '0)
            begin
                pend_byte = d;
                pend_full = 1'b1;
            end
        end
        bv = shifter[bit_pos];
        r  = '0;
        case (line_ph)
            i2cmwe_pkg::PH_START_B:  r.sda = 1'b1;
            i2cmwe_pkg::PH_START_C:  begin r.scl = 1'b1; r.sda = 1'b1; end
            i2cmwe_pkg::PH_BIT_SET:  begin r.scl = 1'b1; r.sda = ~bv; end
            i2cmwe_pkg::PH_BIT_HIGH: r.sda = ~bv;
            i2cmwe_pkg::PH_BIT_LOW:  begin r.scl = 1'b1; r.sda = ~bv; end
            i2cmwe_pkg::PH_ACK_SET,
            i2cmwe_pkg::PH_ACK_LOW,
            i2cmwe_pkg::PH_WAIT_BYTE: r.scl = 1'b1;
            i2cmwe_pkg::PH_STOP_A:   begin r.scl = 1'b1; r.sda = 1'b1; end
            i2cmwe_pkg::PH_STOP_B:   r.sda = 1'b1;
            default:     ;
        endcase
        r.busy = (line_ph != i2cmwe_pkg::PH_IDLE);
        r.want = r.busy && !pend_full && bytes_rem != '0;
        r.done = done;
        r.nk   = done && nack_seen;
        return r;
    endfunction

    task automatic report_fail(input string what, input line_res_t exp_r,
                               input line_res_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s at result %0d: expected scl=%b sda=%b busy=%b want=%b done=%b nack=%b",
                     what, results_seen, exp_r.scl, exp_r.sda, exp_r.busy, exp_r.want,
                     exp_r.done, exp_r.nk);
        if (fail_count <= 10)
            $display("    got scl=%b sda=%b busy=%b want=%b done=%b nack=%b",
                     got.scl, got.sda, got.busy, got.want, got.done, got.nk);
    endtask

    always @(posedge clk)
    begin
        line_res_t got;
        line_res_t exp_r;
        if (rst_n && in_valid && in_stall)
            input_holds++;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {scl_pull_low, sda_pull_low, busy_res, byte_wanted, done_res, nack};
            if (line_results_due.size() == 0)
                report_fail("unexpected word", '0, got);
            else
            begin
                exp_r = line_results_due.pop_front();
                if (got !== exp_r)
                    report_fail("wrong word", exp_r, got);
            end
            results_seen++;
        end
    end

    // output side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 64;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_word(input logic [1:0] rq, input logic [6:0] a,
                             input logic [15:0] n, input logic [7:0] d, input logic s,
                             input logic typed, input line_res_t typed_res);
        line_res_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        addr7      <= a;
        byte_count <= n;
        data_byte  <= d;
        sda_in     <= s;
        do
            @(posedge clk);
        while (in_stall);
        r = line_after_word(rq, a, n, d, s);
        if (r.done && r.nk)
            nack_ends++;
        line_results_due.push_back(typed ? typed_res : r);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_phase_ticks(input logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tick_len = v;
    endtask

    task automatic run_traffic(input int target);
        int start_words, r, feed_pct, nack_pct;
        logic [15:0] n;
        start_words = words_sent;
        feed_pct    = 60;
        while (line_ph != i2cmwe_pkg::PH_IDLE || words_sent - start_words < target)
        begin
            r        = $urandom_range(99);
            nack_pct = (words_sent - start_words > target) ? 50 : 8;
            if (r < 8)
                send_word(2'($urandom_range(3)), 7'($urandom_range(127)),
                          16'($urandom_range(65535)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'b0, '0);
            else if (line_ph == i2cmwe_pkg::PH_IDLE)
            begin
                case ($urandom_range(9))
                    0:       n = '0;
                    7:       n = 16'($urandom_range(5, 12));
                    8:       n = 16'hFFFF;
                    9:       n = 16'($urandom_range(65535));
                    default: n = 16'($urandom_range(1, 4));
                endcase
                feed_pct = ($urandom_range(3) == 0) ? 4 : 60;
                transfers++;
                send_word(i2cmwe_pkg::REQ_CODE_BEGIN, 7'($urandom_range(127)), n,
                          8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            end
            else if (!pend_full && bytes_rem != '0 && $urandom_range(99) < feed_pct)
                send_word(i2cmwe_pkg::REQ_CODE_SUPPLY, 7'($urandom_range(127)),
                          16'($urandom_range(65535)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'b0, '0);
            else
            begin
                rand_ticks++;
                send_word(i2cmwe_pkg::REQ_CODE_TICK, 7'($urandom_range(127)),
                          16'($urandom_range(65535)), 8'($urandom_range(255)),
                          (line_ph == i2cmwe_pkg::PH_ACK_HIGH)
                              ? 1'($urandom_range(99) < nack_pct)
                              : 1'($urandom_range(1)),
                          1'b0, '0);
            end
        end
    endtask

    initial
    begin
        int send_pcts  [4];
        int stall_pcts [4];
        logic [15:0] span_set [4];
        send_pcts  = '{0, 56, 0, 24};
        stall_pcts = '{0, 0, 56, 24};
        span_set   = '{16'd1, 16'd0, 16'd2, 16'($urandom_range(1, 3))};

        // scripted section: zero phase_ticks, so each phase is one tick
        script = '{
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b000000},
            '{i2cmwe_pkg::REQ_NONE,        7'h7F, 16'hFFFF, 8'hFF, 1'b1,  1, 1'b1, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_SUPPLY, 7'h00, 16'h0000, 8'hFF, 1'b0,  1, 1'b1, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_BEGIN,  7'h7F, 16'hFFFF, 8'h00, 1'b0,  1, 1'b1, 6'b001100},
            '{i2cmwe_pkg::REQ_CODE_BEGIN,  7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b001100},
            '{i2cmwe_pkg::REQ_CODE_SUPPLY, 7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b001000},
            '{i2cmwe_pkg::REQ_CODE_SUPPLY, 7'h00, 16'h0000, 8'hFF, 1'b0,  1, 1'b1, 6'b001000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b1,  1, 1'b1, 6'b011000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b111000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b101000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0, 27, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_SUPPLY, 7'h00, 16'h0000, 8'hFF, 1'b0,  1, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0, 25, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b1,  1, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  2, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b000011},
            '{i2cmwe_pkg::REQ_CODE_BEGIN,  7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_SUPPLY, 7'h00, 16'h0000, 8'h5A, 1'b0,  1, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0, 32, 1'b0, 6'b000000},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b000010},
            '{i2cmwe_pkg::REQ_CODE_TICK,   7'h00, 16'h0000, 8'h00, 1'b0,  1, 1'b1, 6'b000000}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_phase_ticks(16'd0);
        foreach (script[i])
            for (int k = 0; k < script[i].reps; k++)
                send_word(script[i].rq, script[i].a, script[i].n, script[i].d,
                          script[i].s, script[i].typed, script[i].res);

        for (int p = 0; p < 4; p++)
        begin
            settle();
            set_phase_ticks(span_set[p]);
            send_idle_pct = send_pcts[p];
            stall_pct     = stall_pcts[p];
            if (p == 0)
                hold_req = 1'b1;
            run_traffic(290);
        end

        // longest phases: the counter runs while START_A holds
        settle();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_phase_ticks(16'hFFFF);
        send_word(i2cmwe_pkg::REQ_CODE_BEGIN, 7'($urandom_range(127)), 16'd1, 8'h00,
                  1'b0, 1'b0, '0);
        send_word(i2cmwe_pkg::REQ_CODE_SUPPLY, 7'h00, 16'h0000, 8'($urandom_range(255)),
                  1'b0, 1'b0, '0);
        for (int k = 0; k < 64; k++)
            send_word(i2cmwe_pkg::REQ_CODE_TICK, 7'h00, 16'h0000, 8'h00,
                      1'($urandom_range(1)), 1'b0, '0);

        settle();
        $display("%0d words in, %0d results checked, %0d random transfers (%0d ended on NACK)",
                 words_sent, results_seen, transfers, nack_ends);
        $display("phase_ticks 0, 1, 2, %0d and 65535; %0d random ticks; input held off %0d cycles",
                 span_set[3], rand_ticks, input_holds);
        if (fail_count == 0)
            $display("i2c_master_write_engine: match");
        else
            $display("i2c_master_write_engine: mismatch");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("run did not complete in time");
        $display("i2c_master_write_engine: mismatch");
        $finish;
    end

endmodule
